FILE: rtl/flpm_pkg.sv
// ----------------------------------------------------------------------------
// Fog and light palette matcher package
// Shared widths, reset values, codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package flpm_pkg;

  // Field widths of the channels.
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned RGB_W     = 24;
  localparam int unsigned LVL_W     = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // Default palette depth.
  localparam int unsigned PALETTE_SIZE_DEF = 256;

  // Configuration reset values.
  localparam logic [CNT_W-1:0] LIGHT_COUNT_RST = 7'd4;
  localparam logic [CNT_W-1:0] FOG_COUNT_RST   = 7'd4;
  localparam logic [RGB_W-1:0] FOG_RGB_RST     = 24'h799ED7;

  // Input command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOG_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOG_RGB     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // input transaction taken this cycle
    logic coef_load;   // latch source color and blend weights
    logic mul;         // form the two channel products
    logic div_load;    // load the rounding divider
    logic div_step;    // one restoring division step
    logic scan_issue;  // read the next palette entry for the search
    logic out_load;    // load the result register
  } flpm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lookup;      // pending input is a lookup
    logic level_err;   // a captured level is not below its count
    logic div_last;    // final division step of a channel
    logic chan_last;   // current channel is the last one
    logic issue_last;  // last palette entry is being read
    logic scan_done;   // last distance is being compared
    logic out_free;    // result register can take a new result
  } flpm_status_t;

endpackage

FILE: rtl/flpm_if.sv
// ----------------------------------------------------------------------------
// Fog and light palette matcher channel interfaces
// Valid/ready channels for commands, results and configuration writes.
// ----------------------------------------------------------------------------

// Command channel: palette writes and lookups.
interface flpm_in_if import flpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [IDX_W-1:0] entry_index;
  logic [RGB_W-1:0] entry_rgb;
  logic [LVL_W-1:0] light_level;
  logic [LVL_W-1:0] fog_level;

  modport source (output valid, command, entry_index, entry_rgb, light_level, fog_level,
                  input ready);
  modport sink   (input valid, command, entry_index, entry_rgb, light_level, fog_level,
                  output ready);
endinterface

// Result channel: one transaction per lookup.
interface flpm_out_if import flpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_distance;
  logic              level_error;

  modport source (output valid, best_index, best_distance, level_error, input ready);
  modport sink   (input valid, best_index, best_distance, level_error, output ready);
endinterface

// Configuration write channel.
interface flpm_cfg_if import flpm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/flpm_ctrl.sv
// ----------------------------------------------------------------------------
// Fog and light palette matcher controller
// Sequences level check, per-channel blend and division, and palette search.
// ----------------------------------------------------------------------------
module flpm_ctrl import flpm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  flpm_status_t status_i,
  output flpm_cmd_t    ctrl_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_LOAD   = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_DRAIN  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
        if (in_valid_i && status_i.lookup) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.level_err) begin
          state_d = S_FINISH;
        end else begin
          ctrl_o.coef_load = 1'b1;
          state_d          = S_MUL;
        end
      end
      S_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        ctrl_o.div_load = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = status_i.chan_last ? S_SCAN : S_MUL;
        end
      end
      S_SCAN: begin
        ctrl_o.scan_issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/flpm_dpath.sv
// ----------------------------------------------------------------------------
// Fog and light palette matcher datapath
// Palette memory, configuration, blend arithmetic, divider and distance search.
// ----------------------------------------------------------------------------
module flpm_dpath import flpm_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  flpm_cmd_t        ctrl_i,
  output flpm_status_t     status_o,
  input  logic             command_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  logic [RGB_W-1:0] entry_rgb_i,
  input  logic [LVL_W-1:0] light_level_i,
  input  logic [LVL_W-1:0] fog_level_i,
  flpm_cfg_if.sink         cfg_ch,
  flpm_out_if.source       out_ch
);

  localparam int unsigned AW = $clog2(PALETTE_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_SIZE - 1);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Configuration registers.
  logic [CNT_W-1:0] light_cnt_q, fog_cnt_q;
  logic [RGB_W-1:0] fog_rgb_q;

  // Palette memory and its registered read port.
  logic [RGB_W-1:0] mem [PALETTE_SIZE];
  logic [RGB_W-1:0] rdata_q;
  logic [AW-1:0]    raddr;
  logic             in_range, mem_we;

  // Lookup operands and blend weights.
  logic [LVL_W-1:0] ll_q, fl_q;
  logic             src_oor_q;
  logic [RGB_W-1:0] src_q;
  logic [CNT_W-1:0] lden, fden, wl, wf;
  logic [13:0]      wlf_q, den_q;
  logic [12:0]      flf_q;
  logic [7:0]       src_ch, fog_ch;
  logic [21:0]      p1_q;
  logic [20:0]      p2_q;
  logic [21:0]      num;

  // Rounding divider.
  logic [22:0]      rem_q;
  logic [21:0]      ds_q;
  logic [7:0]       quo_q;
  logic [2:0]       step_q;
  logic [1:0]       chan_q;
  logic             div_ge;
  logic [7:0]       target_q [3];

  // Search pipeline.
  logic [AW-1:0]     cnt_q, rd_idx_q, d_idx_q, best_idx_q;
  logic              rd_vld_q, d_vld_q;
  logic [DIST_W-1:0] cur_dist, d_q, best_d_q;

  // Result register.
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_index_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_err_q;

  // Configuration writes; indexes past the list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_cnt_q <= LIGHT_COUNT_RST;
      fog_cnt_q   <= FOG_COUNT_RST;
      fog_rgb_q   <= FOG_RGB_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_LIGHT_COUNT: light_cnt_q <= cfg_ch.data[CNT_W-1:0];
        CFG_FOG_COUNT:   fog_cnt_q   <= cfg_ch.data[CNT_W-1:0];
        CFG_FOG_RGB:     fog_rgb_q   <= cfg_ch.data[RGB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Palette memory: written on an in-range write transaction, read every cycle.
  assign in_range = {1'b0, entry_index_i} < 9'(PALETTE_SIZE);
  assign mem_we   = ctrl_i.accept && (command_i == CMD_WRITE) && in_range;
  assign raddr    = ctrl_i.scan_issue ? cnt_q : entry_index_i[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[entry_index_i[AW-1:0]] <= entry_rgb_i;
    end
    rdata_q <= mem[raddr];
  end

  // Level check and blend weights. With a count of one only level zero passes,
  // so the level itself serves as the numerator.
  assign lden = (light_cnt_q > 7'd1) ? light_cnt_q - 7'd1 : 7'd1;
  assign fden = (fog_cnt_q > 7'd1) ? fog_cnt_q - 7'd1 : 7'd1;
  assign wl   = lden - {1'b0, ll_q};
  assign wf   = fden - {1'b0, fl_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      ll_q      <= light_level_i;
      fl_q      <= fog_level_i;
      src_oor_q <= !in_range;
    end
    if (ctrl_i.coef_load) begin
      src_q <= src_oor_q ? '0 : rdata_q;
      wlf_q <= wl * wf;
      flf_q <= 13'(fl_q) * 13'(lden);
      den_q <= lden * fden;
    end
  end

  // Channel selection for the product stage.
  always_comb begin
    case (chan_q)
      CH_RED: begin
        src_ch = src_q[23:16];
        fog_ch = fog_rgb_q[23:16];
      end
      CH_GREEN: begin
        src_ch = src_q[15:8];
        fog_ch = fog_rgb_q[15:8];
      end
      default: begin
        src_ch = src_q[7:0];
        fog_ch = fog_rgb_q[7:0];
      end
    endcase
  end

  // Products of the exact blend numerator; the sum is at most 255 * den.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      p1_q <= src_ch * wlf_q;
      p2_q <= fog_ch * flf_q;
    end
  end

  assign num    = p1_q + 22'(p2_q);
  assign div_ge = {1'b0, ds_q} <= rem_q;

  // Round half up: (2 * num + den) / (2 * den), one quotient bit a step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      rem_q <= {num, 1'b0} + 23'(den_q);
      ds_q  <= {den_q, 8'b0};
    end else if (ctrl_i.div_step) begin
      rem_q <= div_ge ? rem_q - {1'b0, ds_q} : rem_q;
      ds_q  <= ds_q >> 1;
      quo_q <= {quo_q[6:0], div_ge};
      if (step_q == 3'd7) begin
        target_q[chan_q] <= {quo_q[6:0], div_ge};
      end
    end
  end

  // Division step and channel counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      chan_q <= CH_RED;
    end else if (ctrl_i.div_step) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd7) begin
        chan_q <= (chan_q == CH_BLUE) ? CH_RED : chan_q + 2'd1;
      end
    end
  end

  // Squared distance of the entry just read to the blended color.
  always_comb begin
    logic [7:0]  a, t, diff;
    logic [15:0] sq;
    cur_dist = '0;
    for (int k = 0; k < 3; k++) begin
      a        = rdata_q[23 - 8 * k -: 8];
      t        = target_q[k];
      diff     = (a > t) ? a - t : t - a;
      sq       = diff * diff;
      cur_dist = cur_dist + DIST_W'(sq);
    end
  end

  // Search pipeline control: read, distance, compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      d_vld_q  <= 1'b0;
    end else begin
      if (ctrl_i.scan_issue) begin
        cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + AW'(1);
      end
      rd_vld_q <= ctrl_i.scan_issue;
      d_vld_q  <= rd_vld_q;
    end
  end

  // The first entry always seeds the minimum; later ones replace it only
  // when strictly nearer, which keeps the lowest index on ties.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    d_idx_q  <= rd_idx_q;
    d_q      <= cur_dist;
    if (d_vld_q && ((d_idx_q == '0) || (d_q < best_d_q))) begin
      best_idx_q <= d_idx_q;
      best_d_q   <= d_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_index_q <= status_o.level_err ? '0 : IDX_W'(best_idx_q);
      out_dist_q  <= status_o.level_err ? '0 : best_d_q;
      out_err_q   <= status_o.level_err;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.best_index    = out_index_q;
  assign out_ch.best_distance = out_dist_q;
  assign out_ch.level_error   = out_err_q;

  // Status to the controller.
  assign status_o.lookup     = (command_i == CMD_LOOKUP);
  assign status_o.level_err  = ({1'b0, ll_q} >= light_cnt_q) || ({1'b0, fl_q} >= fog_cnt_q);
  assign status_o.div_last   = (step_q == 3'd7);
  assign status_o.chan_last  = (chan_q == CH_BLUE);
  assign status_o.issue_last = (cnt_q == LAST_IDX);
  assign status_o.scan_done  = d_vld_q && (d_idx_q == LAST_IDX);
  assign status_o.out_free   = !out_valid_q || out_ch.ready;

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> (!out_valid_q || out_ch.ready))
    else $error("result register loaded while still occupied");

  // After the last step the remainder is below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.div_step && (step_q == 3'd7)) |=> (rem_q < {8'b0, den_q, 1'b0}))
    else $error("rounding division left a remainder above the divisor");

  // The entry counter is back at zero when the search completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.scan_done |-> (cnt_q == '0))
    else $error("palette search ended with the entry counter out of step");

  // An error result carries a zero index and distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> ((out_index_q == '0) && (out_dist_q == '0)))
    else $error("error result with nonzero payload");

endmodule

FILE: rtl/fog_light_palette_matcher.sv
// ----------------------------------------------------------------------------
// Fog and light palette matcher
// Nearest palette color search for a lit and fogged palette color.
// ----------------------------------------------------------------------------
// A palette write transaction leaves the block idle, ready for the next one.
// A lookup darkens the source entry by its light level, blends it toward the
// fog color by its fog level, rounds each channel half up once, and returns
// the lowest palette index at the smallest squared RGB distance. A lookup
// occupies the block through capture and level check, the products and the
// bit-serial rounding divider for each channel, one palette entry per cycle
// through the single memory read port and distance unit, and the drain of the
// search pipeline and the load of the result. A lookup whose level is not
// below its count returns an error result without the blend and the search.
// The result register lets the next transaction be taken while a result waits.
// Entries never written read as unknown colors, both as a source and during
// the search. Configuration writes take effect at once and are meant for idle
// periods only.
module fog_light_palette_matcher import flpm_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flpm_in_if.sink     in_ch,
  flpm_out_if.source  out_ch,
  flpm_cfg_if.sink    cfg_ch
);

  flpm_cmd_t    ctrl;
  flpm_status_t status;
  logic         in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  flpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // Storage and arithmetic.
  flpm_dpath #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .command_i     (in_ch.command),
    .entry_index_i (in_ch.entry_index),
    .entry_rgb_i   (in_ch.entry_rgb),
    .light_level_i (in_ch.light_level),
    .fog_level_i   (in_ch.fog_level),
    .cfg_ch        (cfg_ch),
    .out_ch        (out_ch)
  );

endmodule
